// ===== src/jump_consistent_hash_bucket_macros.svh =====
// Assertion macros used by the checker file of the bucket selector.
`ifndef JUMP_CONSISTENT_HASH_BUCKET_MACROS_SVH
`define JUMP_CONSISTENT_HASH_BUCKET_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JCH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jch assertion failed");

// Next-cycle implication, checked outside reset.
`define JCH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jch assertion failed");

`endif

// ===== src/jch_pkg.sv =====
// Types and constants of the jump consistent hash bucket selector.
package jch_pkg;

  localparam int unsigned KeyW      = 64;
  localparam int unsigned HalfW     = 32;
  localparam int unsigned CntW      = 31;
  localparam int unsigned KeyShift  = 33;
  localparam int unsigned ScaleSh   = 31;
  localparam int unsigned NumW      = CntW + ScaleSh;   // shifted numerator width
  localparam int unsigned DenW      = KeyW - KeyShift + 1;
  localparam int unsigned RemW      = DenW + 1;
  localparam int unsigned StepCntW  = $clog2(NumW);

  localparam logic [KeyW-1:0] LcgMult = 64'h27BB_2EE6_87B0_B0FD;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LL,
    S_MUL_LH,
    S_MUL_HL,
    S_KEY,
    S_DLOAD,
    S_DIV,
    S_CHECK
  } jch_state_e;

  typedef struct packed {
    logic start;
  } jch_div_req_t;

  typedef struct packed {
    logic done;
  } jch_div_rsp_t;

endpackage

// ===== src/jch_div.sv =====
// Restoring radix-2 divider: one quotient bit per cycle.
module jch_div
  import jch_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jch_div_req_t    req_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output jch_div_rsp_t    rsp_o,
  output logic [NumW-1:0] quot_o
);

  logic                run_q;
  logic                done_q;
  logic [StepCntW-1:0] cnt_q;
  logic [RemW-1:0]     rem_q;
  logic [NumW-1:0]     quo_q;
  logic [DenW-1:0]     den_q;

  logic [RemW-1:0]     trial;
  logic                fits;

  // Shift one numerator bit into the partial remainder and try the subtract.
  assign trial = {rem_q[RemW-2:0], quo_q[NumW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == StepCntW'(NumW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + StepCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
      quo_q <= {quo_q[NumW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign quot_o     = quo_q;

endmodule

// ===== src/jump_consistent_hash_bucket.sv =====
// Jump consistent hash bucket selector: top level with sequencer and shared multiplier.
//
// Usage: a 64-bit hashed key enters on the input channel (in_valid_i / in_stall_o,
// payload hash_key_i) and one bucket index below the configured bucket count
// leaves on the output channel (out_valid_o / out_stall_i, payload bucket_index_o).
// A word moves at a rising edge where valid is high and stall is low.
// The bucket count is written over the APB-style port at byte address 0; a
// count of zero acts as one. Write it only while the block is idle.
// Each loop pass advances the key by a 64-bit multiply-add built from three
// 32x32 partial products on one shared multiplier, loads the divider, then
// runs a 62-step restoring division one quotient bit per cycle and checks the
// jump target, waiting there while the output register is full and stalled.
// A key takes about ln(bucket_count) + 1 passes.
// One key is worked at a time: in_stall_o is high from acceptance until the
// result is loaded into the output register. The result register holds while
// out_stall_i is high, and the next key is taken while it waits.
// Reset clears the sequencer and output valid, and sets the bucket count to 1.
module jump_consistent_hash_bucket
  import jch_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  // input channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [KeyW-1:0] hash_key_i,
  // output channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [CntW-1:0] bucket_index_o
);

  jch_state_e       state_q, state_d;

  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  count_eff;
  logic [KeyW-1:0]  key_q;
  logic [KeyW-1:0]  acc_q;
  logic [KeyW-1:0]  prod_q;
  logic [CntW-1:0]  cur_q;
  logic             out_valid_q;
  logic [CntW-1:0]  out_q;

  logic [HalfW-1:0] mul_a;
  logic [HalfW-1:0] mul_b;
  logic [KeyW-1:0]  mul_res;

  jch_div_req_t     div_req;
  jch_div_rsp_t     div_rsp;
  logic [NumW-1:0]  div_num;
  logic [DenW-1:0]  div_den;
  logic [NumW-1:0]  quot;

  logic             in_acc;
  logic             out_free;
  logic             pass_last;
  logic             load_out;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign prdata = {1'b0, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(1);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      count_q <= pwdata[CntW-1:0];
    end
  end

  assign count_eff = (count_q == '0) ? CntW'(1) : count_q;

  // ---------------------------------------------------------------- sequencer
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pass_last  = (quot >= {{(NumW-CntW){1'b0}}, count_eff});

  always_comb begin
    state_d       = state_q;
    div_req.start = 1'b0;
    load_out      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_MUL_LL;
      end
      S_MUL_LL: begin
        mul_a   = key_q[HalfW-1:0];
        mul_b   = LcgMult[HalfW-1:0];
        state_d = S_MUL_LH;
      end
      S_MUL_LH: begin
        mul_a   = key_q[HalfW-1:0];
        mul_b   = LcgMult[KeyW-1:HalfW];
        state_d = S_MUL_HL;
      end
      S_MUL_HL: begin
        mul_a   = key_q[KeyW-1:HalfW];
        mul_b   = LcgMult[HalfW-1:0];
        state_d = S_KEY;
      end
      S_KEY: begin
        state_d = S_DLOAD;
      end
      S_DLOAD: begin
        div_req.start = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) state_d = S_CHECK;
      end
      S_CHECK: begin
        // Target at or past the count ends the walk; hold until the output frees.
        if (!pass_last) begin
          state_d = S_MUL_LL;
        end else if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- datapath
  assign mul_res = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_res;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          key_q <= hash_key_i;
          cur_q <= '0;
        end
      end
      // Fold the LCG increment into the low partial product.
      S_MUL_LH: acc_q <= prod_q + KeyW'(1);
      S_MUL_HL: acc_q[KeyW-1:HalfW] <= acc_q[KeyW-1:HalfW] + prod_q[HalfW-1:0];
      S_KEY:    key_q <= {acc_q[KeyW-1:HalfW] + prod_q[HalfW-1:0], acc_q[HalfW-1:0]};
      S_CHECK: begin
        if (!pass_last) cur_q <= quot[CntW-1:0];
      end
      default: ;
    endcase
  end

  assign div_num = {cur_q + CntW'(1), {ScaleSh{1'b0}}};
  assign div_den = {1'b0, key_q[KeyW-1:KeyShift]} + DenW'(1);

  jch_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .rsp_o  (div_rsp),
    .quot_o (quot)
  );

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= cur_q;
  end

  assign out_valid_o    = out_valid_q;
  assign bucket_index_o = out_q;

endmodule

// ===== src/jch_chk.sv =====
// Port-level assertion checker for the bucket selector, with its bind.
`include "jump_consistent_hash_bucket_macros.svh"

module jch_chk
  import jch_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic [31:0]     prdata,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [CntW-1:0] bucket_index_o
);

  logic [31:0] count_eff;

  // A count of zero acts as one.
  assign count_eff = (prdata == '0) ? 32'd1 : prdata;

  `JCH_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `JCH_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(bucket_index_o))
  `JCH_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `JCH_ASSERT_NOW(a_index_range, out_valid_o, {1'b0, bucket_index_o} < count_eff)

endmodule

bind jump_consistent_hash_bucket jch_chk u_jch_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .prdata         (prdata),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .bucket_index_o (bucket_index_o)
);

// ===== tb/tb_jump_consistent_hash_bucket.sv =====
// Testbench for the jump consistent hash bucket selector, with its own bucket predictor.
module tb_jump_consistent_hash_bucket;
  import jch_pkg::*;

  // Byte addresses on the configuration port; index 1 has no register behind it.
  localparam logic [2:0] BucketCountAddr = 3'd0;
  localparam logic [2:0] UnusedAddr      = 3'd4;
  localparam logic [CntW-1:0] CountMask  = '1;
  // Longest deliberate hold of the receiver, and the quiet stretch that ends the run.
  localparam int HoldCycles  = 3000;
  localparam int QuietLimit  = 30000;
  localparam int PhaseWords  = 200;

  typedef enum int {
    StallNone,
    StallCoin,
    StallPeriodic,
    StallSparse
  } stall_mode_e;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [2:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [KeyW-1:0] hash_key_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [CntW-1:0] bucket_index_o;

  // Shadow of the bucket count register, as the block should hold it.
  logic [CntW-1:0] shadow_count = CntW'(1);
  // Buckets still owed by the block, oldest first.
  logic [CntW-1:0] expected_buckets[$];

  int          fail_count = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  int          mode_left = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  stall_mode_e stall_mode = StallNone;

  jump_consistent_hash_bucket dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .hash_key_i     (hash_key_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bucket_index_o (bucket_index_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Jump consistent hash in exact integer form: advance the key with the
  // 64-bit LCG, jump to floor(((b+1) << 31) / ((key >> 33) + 1)), stop once
  // the jump lands at or past the count. A count of zero behaves as one.
  function automatic logic [CntW-1:0] jump_bucket(logic [KeyW-1:0] key,
                                                  logic [CntW-1:0] count);
    logic [KeyW-1:0] limit;
    logic [KeyW-1:0] kept;
    logic [KeyW-1:0] jump_to;
    limit   = (count == '0) ? 64'd1 : KeyW'(count);
    kept    = '0;
    jump_to = '0;
    while (jump_to < limit) begin
      kept    = jump_to;
      key     = key * LcgMult + 64'd1;
      jump_to = ((kept + 64'd1) << ScaleSh) / ((key >> KeyShift) + 64'd1);
    end
    return kept[CntW-1:0];
  endfunction

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where penable and pready are both high. Mirror the write in the shadow.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == BucketCountAddr) shadow_count = data[CntW-1:0] & CountMask;
  endtask

  // Offer one key. Between bursts drop valid for a random gap: mostly short,
  // sometimes long enough to land anywhere inside a multi-pass computation.
  task automatic send_key(input logic [KeyW-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    hash_key_i <= key;
    // Hold the word until the block takes it.
    do @(posedge clk_i); while (in_stall_o);
    expected_buckets.push_back(jump_bucket(key, shadow_count));
  endtask

  // Drop valid and wait until every owed bucket has come back; the block is
  // then idle, since each key yields exactly one word.
  task automatic drain;
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_buckets.size() != 0);
  endtask

  // Reset value of the count is one, so every key lands in bucket zero.
  task automatic test_reset_count;
    send_key('0);
    send_key('1);
    send_key(64'h8000_0000_0000_0000);
    send_key(64'h0000_0001_FFFF_FFFF);
    drain();
  endtask

  // A count of zero acts as one.
  task automatic test_zero_count;
    write_reg(BucketCountAddr, 32'd0);
    send_key(64'h0000_0000_0000_0001);
    send_key(64'hFFFF_FFFE_0000_0000);
    send_key({$urandom(), $urandom()});
    drain();
  endtask

  // Only the low 31 bits of a written count are kept: the all-ones word gives
  // the largest count, where keys take the most passes.
  task automatic test_wide_write;
    write_reg(BucketCountAddr, 32'hFFFF_FFFF);
    send_key('0);
    send_key('1);
    send_key(64'h0000_0001_FFFF_FFFF);
    send_key(64'h0000_0002_0000_0000);
    send_key(64'h5555_5555_5555_5555);
    send_key(64'hAAAA_AAAA_AAAA_AAAA);
    drain();
    write_reg(BucketCountAddr, 32'h8000_0003);
    send_key({$urandom(), $urandom()});
    send_key({$urandom(), $urandom()});
    drain();
  endtask

  // Writes to an address with no register must leave the count alone.
  task automatic test_unused_address;
    write_reg(BucketCountAddr, 32'd37);
    write_reg(UnusedAddr, 32'd2);
    send_key({$urandom(), $urandom()});
    send_key({$urandom(), $urandom()});
    send_key({$urandom(), $urandom()});
    drain();
  endtask

  // Sweep a list of small and large counts; large counts get few keys since each
  // key then needs many passes.
  task automatic test_random_counts;
    logic [31:0] counts[10];
    int          words;
    counts = '{32'd2, 32'd3, 32'd5, 32'd16, 32'd100, 32'd1000, 32'd4096,
               32'd0, 32'd0, 32'h7FFF_FFFF};
    counts[7] = $urandom_range(1, 64);
    counts[8] = $urandom_range(65, 10000);
    foreach (counts[i]) begin
      write_reg(BucketCountAddr, counts[i]);
      words = (counts[i] > 32'd100000) ? 20 : PhaseWords;
      repeat (words) begin
        if ($urandom_range(0, 7) == 0) send_key(KeyW'($urandom()));
        else send_key({$urandom(), $urandom()});
      end
      drain();
    end
  endtask

  // Hold the receiver off for a long stretch while keys keep coming, so the
  // block parks a result and then stalls its input.
  task automatic test_backpressure;
    write_reg(BucketCountAddr, 32'd12);
    hold_req = 1'b1;
    burst_left = 40;
    repeat (8) send_key({$urandom(), $urandom()});
    drain();
  endtask

  // Receiver stall: switch between stall patterns every so often, including
  // stretches with no stall at all; a long hold overrides the pattern.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      case (stall_mode)
        StallNone:     out_stall_i <= 1'b0;
        StallCoin:     out_stall_i <= ($urandom_range(0, 1) == 1);
        StallPeriodic: out_stall_i <= ((mode_left % 8) < 3);
        default:       out_stall_i <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Check each accepted word against the oldest owed bucket.
  always @(posedge clk_i) begin : check_word
    logic [CntW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_buckets.size() == 0) begin
        $error("bucket_index: expected none, actual %0d", bucket_index_o);
        fail_count++;
      end else begin
        want = expected_buckets.pop_front();
        if (bucket_index_o !== want) begin
          $error("bucket_index: expected %0d, actual %0d", want, bucket_index_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_count();
    test_zero_count();
    test_wide_write();
    test_unused_address();
    test_backpressure();
    test_random_counts();
    // Let any stray word show up before the verdict.
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/jch_pkg.sv
src/jch_div.sv
src/jump_consistent_hash_bucket.sv
src/jch_chk.sv
tb/tb_jump_consistent_hash_bucket.sv
